/* rtl/rhss_pkg.sv */
// Shared widths, defaults and register addresses for the rolling hash search block.
// No dependencies; imported by rhss_mod_reduce and rolling_hash_substring_search.
package rhss_pkg;

  localparam int unsigned MAX_PATTERN_DEF  = 8;
  localparam int unsigned HASH_MODULUS_DEF = 35317;

  localparam int unsigned CHAR_W  = 8;   // text and pattern byte
  localparam int unsigned LEN_W   = 4;   // pattern_length register
  localparam int unsigned HASH_W  = 16;  // stored hash and residues
  localparam int unsigned VAL_W   = 18;  // operand range of the modulo reducer
  localparam int unsigned RECIP_W = 32;  // reciprocal scale for the reducer
  localparam int unsigned APB_DW  = 64;
  localparam int unsigned APB_AW  = 4;

  // Register map, 8-byte stride; only paddr[3] is decoded.
  typedef enum logic [0:0] {
    REG_PATTERN_BYTES  = 1'b0,
    REG_PATTERN_LENGTH = 1'b1
  } reg_idx_t;

  // Sideband flags that ride along the hash pipeline.
  typedef struct packed {
    logic valid;
    logic match_en;
    logic last;
  } stage_t;

endpackage

/* rtl/rhss_mod_reduce.sv */
// Two-stage reduction of an unsigned value modulo a constant prime.
// Uses rhss_pkg widths; quotient by reciprocal multiply, then one correction.
module rhss_mod_reduce import rhss_pkg::*; #(
  parameter int unsigned HASH_MODULUS = HASH_MODULUS_DEF
) (
  input  logic              clk,
  input  logic              en_quot,
  input  logic              en_rem,
  input  logic [VAL_W-1:0]  v,
  output logic [HASH_W-1:0] r
);

  localparam int unsigned PROD_W = VAL_W + RECIP_W;
  localparam int unsigned QQ_W   = VAL_W + HASH_W;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_W) / HASH_MODULUS);
  localparam logic [HASH_W-1:0]  MODQ  = HASH_W'(HASH_MODULUS);

  logic [PROD_W-1:0] prod;
  logic [VAL_W-1:0]  v_q;
  logic [VAL_W-1:0]  quot_q;
  logic [QQ_W-1:0]   qq;
  logic [VAL_W-1:0]  rem_raw;
  logic [VAL_W-1:0]  rem_fix;

  // Estimate is exact or one low, so the remainder lands in [0, 2q).
  assign prod = PROD_W'(v) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (en_quot) begin
      v_q    <= v;
      quot_q <= prod[RECIP_W +: VAL_W];
    end
  end

  assign qq      = QQ_W'(quot_q) * QQ_W'(MODQ);
  assign rem_raw = v_q - qq[VAL_W-1:0];
  assign rem_fix = (rem_raw >= VAL_W'(MODQ)) ? rem_raw - VAL_W'(MODQ) : rem_raw;

  always_ff @(posedge clk) begin
    if (en_rem) begin
      r <= rem_fix[HASH_W-1:0];
    end
  end

endmodule

/* rtl/rolling_hash_substring_search.sv */
// Rolling hash substring search: radix-2 hash of the last M text bytes, compared
// with the pattern hash. Depends on rhss_pkg and rhss_mod_reduce.
//
//  channel  direction  payload                              handshake
//  in       input      text_char, last_char                 in_valid / in_stall
//  out      output     window_match, found, text_end        out_valid / out_stall
//  cfg      APB        pattern_bytes @0x0, pattern_length @0x8   psel/penable, pready=1
//
// One byte per cycle sustained while out_stall is low; the result passes
// through four register stages: input, the two-stage modulo reducer and the
// hash update stage.
// Each stage holds only while the stage after it is full and stalled, so the
// input keeps taking bytes until all four stages are occupied.
// Synchronous reset clears the text state and sets pattern_length to 1.
module rolling_hash_substring_search import rhss_pkg::*; #(
  parameter int unsigned MAX_PATTERN  = MAX_PATTERN_DEF,
  parameter int unsigned HASH_MODULUS = HASH_MODULUS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CHAR_W-1:0] text_char,
  input  logic              last_char,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              window_match,
  output logic              found,
  output logic              text_end,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int unsigned WIN_IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int unsigned X_W       = CHAR_W + MAX_PATTERN - 1;
  // Multiple of q at or above any dropped term, keeps the reducer operand positive.
  localparam int unsigned WRAP =
    HASH_MODULUS * (((2 ** X_W) + HASH_MODULUS - 1) / HASH_MODULUS);
  localparam logic [HASH_W-1:0] MODQ   = HASH_W'(HASH_MODULUS);
  localparam logic [VAL_W-1:0]  MODQ1  = VAL_W'(HASH_MODULUS);
  localparam logic [VAL_W-1:0]  MODQ2  = VAL_W'(2 * HASH_MODULUS);
  localparam logic [LEN_W-1:0]  LEN_MAX = LEN_W'(MAX_PATTERN);
  localparam logic [LEN_W-1:0]  SEEN_SAT = '1;

  // Configuration
  logic [APB_DW-1:0] pattern_bytes;
  logic [LEN_W-1:0]  pattern_length;
  logic              cfg_wr;
  reg_idx_t          cfg_idx;

  // Text state at the input side
  logic [CHAR_W-1:0] win [MAX_PATTERN];
  logic [LEN_W-1:0]  bytes_seen;
  logic [LEN_W-1:0]  seen_next;
  logic [LEN_W-1:0]  m_eff;
  logic [LEN_W-1:0]  m_dec;
  logic [CHAR_W-1:0] oldest;
  logic [X_W-1:0]    drop_x;
  logic [VAL_W-1:0]  v_next;
  logic              accept;

  // Pipeline
  stage_t            s1, s2, s3;
  logic [VAL_W-1:0]  s1_v;
  logic [HASH_W-1:0] k3;
  logic              en_out, en3, en2, en1;

  // Hash state at the output side
  logic [HASH_W-1:0] text_hash;
  logic              found_flag;
  logic [VAL_W-1:0]  dbl;
  logic [VAL_W-1:0]  t_red;
  logic [HASH_W-1:0] t_next;
  logic              match;

  // Pattern hash
  logic [HASH_W-1:0] pat_sum;
  logic [VAL_W-1:0]  pat_v;
  logic [HASH_W-1:0] pat_hash;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[3]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes  <= '0;
      pattern_length <= LEN_W'(1);
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_PATTERN_BYTES:  pattern_bytes  <= pwdata;
        REG_PATTERN_LENGTH: pattern_length <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_PATTERN_BYTES:  prdata = pattern_bytes;
      REG_PATTERN_LENGTH: prdata = APB_DW'(pattern_length);
      default:            prdata = '0;
    endcase
  end

  // Zero acts as one, anything past the window depth is clamped.
  always_comb begin
    if (pattern_length == '0) begin
      m_eff = LEN_W'(1);
    end else if (pattern_length > LEN_MAX) begin
      m_eff = LEN_MAX;
    end else begin
      m_eff = pattern_length;
    end
  end
  assign m_dec = m_eff - LEN_W'(1);

  // ---------------- pattern hash ----------------
  // Radix-2 value of the pattern stays below 2^16, then reduced mod q.
  always_comb begin
    pat_sum = '0;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (LEN_W'(i) < m_eff) begin
        pat_sum = pat_sum
                + (HASH_W'(pattern_bytes[CHAR_W*i +: CHAR_W]) << (m_dec - LEN_W'(i)));
      end
    end
  end

  always_ff @(posedge clk) begin
    pat_v <= VAL_W'(pat_sum);
  end

  rhss_mod_reduce #(
    .HASH_MODULUS(HASH_MODULUS)
  ) u_pat_reduce (
    .clk    (clk),
    .en_quot(1'b1),
    .en_rem (1'b1),
    .v      (pat_v),
    .r      (pat_hash)
  );

  // ---------------- handshake ----------------
  assign en_out   = !out_valid || !out_stall;
  assign en3      = !s3.valid || en_out;
  assign en2      = !s2.valid || en3;
  assign en1      = !s1.valid || en2;
  assign in_stall = !en1;
  assign accept   = in_valid && en1;

  // ---------------- input side: window and drop term ----------------
  assign oldest    = win[m_dec[WIN_IDX_W-1:0]];
  assign seen_next = (bytes_seen == SEEN_SAT) ? SEEN_SAT : bytes_seen + LEN_W'(1);
  assign drop_x    = (bytes_seen >= m_eff) ? (X_W'(oldest) << m_dec) : '0;
  // (c - 2*drop) mod q is taken by the reducer; WRAP keeps it non-negative.
  assign v_next    = VAL_W'(text_char) + (VAL_W'(WRAP) << 1) - (VAL_W'(drop_x) << 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen <= '0;
      for (int i = 0; i < MAX_PATTERN; i++) begin
        win[i] <= '0;
      end
    end else if (accept) begin
      if (last_char) begin
        bytes_seen <= '0;
        for (int i = 0; i < MAX_PATTERN; i++) begin
          win[i] <= '0;
        end
      end else begin
        bytes_seen <= seen_next;
        win[0]     <= text_char;
        for (int i = 1; i < MAX_PATTERN; i++) begin
          win[i] <= win[i-1];
        end
      end
    end
  end

  // ---------------- pipeline ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
      s2.valid <= 1'b0;
      s3.valid <= 1'b0;
    end else begin
      if (en1) s1.valid <= in_valid;
      if (en2) s2.valid <= s1.valid;
      if (en3) s3.valid <= s2.valid;
    end
    if (en1) begin
      s1.match_en <= (seen_next >= m_eff);
      s1.last     <= last_char;
      s1_v        <= v_next;
    end
    if (en2) begin
      s2.match_en <= s1.match_en;
      s2.last     <= s1.last;
    end
    if (en3) begin
      s3.match_en <= s2.match_en;
      s3.last     <= s2.last;
    end
  end

  rhss_mod_reduce #(
    .HASH_MODULUS(HASH_MODULUS)
  ) u_txt_reduce (
    .clk    (clk),
    .en_quot(en2),
    .en_rem (en3),
    .v      (s1_v),
    .r      (k3)
  );

  // ---------------- hash update and compare ----------------
  assign dbl = (VAL_W'(text_hash) << 1) + VAL_W'(k3);

  always_comb begin
    if (dbl >= MODQ2) begin
      t_red = dbl - MODQ2;
    end else if (dbl >= MODQ1) begin
      t_red = dbl - MODQ1;
    end else begin
      t_red = dbl;
    end
  end
  assign t_next = t_red[HASH_W-1:0];
  assign match  = s3.match_en && (t_next == pat_hash);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      text_hash  <= '0;
      found_flag <= 1'b0;
    end else if (en_out) begin
      out_valid <= s3.valid;
      if (s3.valid) begin
        text_hash  <= s3.last ? '0 : t_next;
        found_flag <= s3.last ? 1'b0 : (found_flag || match);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_out && s3.valid) begin
      window_match <= match;
      found        <= found_flag || match;
      text_end     <= s3.last;
    end
  end

  // ---------------- assertions ----------------
  a_stall_needs_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1.valid)
    else $error("input stalled with first stage empty");

  a_hash_in_range: assert property (@(posedge clk) disable iff (rst)
    text_hash < MODQ)
    else $error("text hash not reduced below modulus");

  a_match_sets_found: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!window_match || found))
    else $error("window match reported without found");

  a_last_clears_count: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && last_char) |=> (bytes_seen == '0))
    else $error("byte count not cleared after end of text");

endmodule
